[hw/rtl/url_path_traversal_checker_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the URL path traversal checker
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef URL_PATH_TRAVERSAL_CHECKER_UNIT_ASSERT_SVH
`define URL_PATH_TRAVERSAL_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define UPTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("uptc assertion failed");

`define UPTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("uptc assertion failed");

`else

`define UPTC_ASSERT_SAME(lbl, ante, cons)

`define UPTC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/uptc_pkg.sv]
// ---------------------------------------------------------------------------
// uptc_pkg
// Shared types, constants and byte helpers for the path traversal checker.
// ---------------------------------------------------------------------------
package uptc_pkg;

    localparam int SEG_BUF = 2048;
    localparam int CNT_W   = $clog2(SEG_BUF);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SEG_BUF - 1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_EMPTY    = 4'd1,
        ST_NO_SLASH = 4'd2,
        ST_BS_COLON = 4'd3,
        ST_CTRL     = 4'd4,
        ST_BAD_ESC  = 4'd5,
        ST_UNSAFE   = 4'd6,
        ST_TOO_LONG = 4'd7,
        ST_DOT      = 4'd8
    } status_t;

    typedef struct packed {
        logic       is_zero;
        logic       is_slash;
        logic       is_pct;
        logic       is_bs_colon;
        logic       is_ctrl;
        logic       hex_ok;
        logic [3:0] hex_val;
    } byte_class_t;

    function automatic logic is_unsafe(input logic [7:0] c);
        logic r;
        r = (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_COLON) || (c == 8'h00);
        return r;
    endfunction

endpackage

[hw/rtl/uptc_byte_class.sv]
// ---------------------------------------------------------------------------
// uptc_byte_class
// Classifies one raw path byte and decodes it as a hex digit.
// ---------------------------------------------------------------------------
module uptc_byte_class import uptc_pkg::*; (
    input  logic [7:0]  path_byte,
    output byte_class_t cls
);

    logic [7:0] lc_off;
    logic [7:0] uc_off;

    assign lc_off = path_byte - 8'h57;
    assign uc_off = path_byte - 8'h37;

    always_comb begin
        cls.is_zero     = (path_byte == 8'h00);
        cls.is_slash    = (path_byte == CH_SLASH);
        cls.is_pct      = (path_byte == CH_PCT);
        cls.is_bs_colon = (path_byte == CH_BSLASH) || (path_byte == CH_COLON);
        cls.is_ctrl     = (path_byte < CH_SPACE) || (path_byte == CH_DEL);
        cls.hex_ok      = 1'b0;
        cls.hex_val     = 4'd0;
        if (path_byte >= 8'h30 && path_byte <= 8'h39) begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = path_byte[3:0];
        end else if (path_byte >= 8'h61 && path_byte <= 8'h66) begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = lc_off[3:0];
        end else if (path_byte >= 8'h41 && path_byte <= 8'h46) begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = uc_off[3:0];
        end
    end

endmodule

[hw/rtl/url_path_traversal_checker_unit.sv]
// ---------------------------------------------------------------------------
// url_path_traversal_checker_unit
// Checks a streamed resource path for traversal and encoding hazards.
// ---------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_path_byte carries one raw path byte per
// beat. A zero byte ends the path; only that beat produces a result on the
// m_valid/m_ready/m_status channel, all other beats produce none.
// Throughput: one byte per cycle. All per-byte work (classification, escape
// decode, segment checks) is one combinational pass into the state
// registers. The status appears on m_status in the cycle after the
// terminating beat is accepted, held in an output register.
// s_ready is high whenever that output register is empty or is being
// drained this cycle. While a status waits on a stalled receiver, s_ready
// is low and every input beat stalls until the status is taken.
// Reset (aresetn low, synchronous) clears the path state and the output
// valid; the next byte is treated as the first byte of a new path.
// ---------------------------------------------------------------------------
`include "url_path_traversal_checker_unit_assert.svh"

module url_path_traversal_checker_unit import uptc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_path_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_status
);

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    typedef enum logic [1:0] {
        RAW_NONE     = 2'd0,
        RAW_BS_COLON = 2'd1,
        RAW_CTRL     = 2'd2
    } raw_t;

    byte_class_t cls;

    logic             first_reg,  first_next;
    logic             start_bad_reg, start_bad_next;
    raw_t             raw_reg,    raw_next;
    status_t          seg_reg,    seg_next;
    esc_t             esc_reg,    esc_next;
    logic [3:0]       hi_reg,     hi_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             dots_reg,   dots_next;
    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg, m_status_next;

    logic       accept;
    logic       take;
    logic [7:0] dec_byte;
    status_t    new_code;
    status_t    end_code;
    status_t    final_seg;

    uptc_byte_class u_class (
        .path_byte (s_path_byte),
        .cls       (cls)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    always_comb begin
        end_code = ST_OK;
        if (esc_reg != ESC_NONE) begin
            end_code = ST_BAD_ESC;
        end else if (dots_reg && cnt_reg != '0 && cnt_reg <= CNT_TWO) begin
            end_code = ST_DOT;
        end
        final_seg = (seg_reg != ST_OK) ? seg_reg : end_code;
    end

    always_comb begin
        first_next     = first_reg;
        start_bad_next = start_bad_reg;
        raw_next       = raw_reg;
        esc_next       = esc_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        dots_next      = dots_reg;
        new_code       = ST_OK;
        take           = 1'b0;
        dec_byte       = s_path_byte;
        m_status_next  = m_status_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (accept) begin
            if (cls.is_zero) begin
                m_valid_next = 1'b1;
                if (first_reg) begin
                    m_status_next = ST_EMPTY;
                end else if (start_bad_reg) begin
                    m_status_next = ST_NO_SLASH;
                end else if (raw_reg == RAW_BS_COLON) begin
                    m_status_next = ST_BS_COLON;
                end else if (raw_reg == RAW_CTRL) begin
                    m_status_next = ST_CTRL;
                end else begin
                    m_status_next = final_seg;
                end
                first_next     = 1'b1;
                start_bad_next = 1'b0;
                raw_next       = RAW_NONE;
                esc_next       = ESC_NONE;
                hi_next        = 4'd0;
                cnt_next       = '0;
                dots_next      = 1'b1;
            end else begin
                if (raw_reg == RAW_NONE) begin
                    if (cls.is_bs_colon) begin
                        raw_next = RAW_BS_COLON;
                    end else if (cls.is_ctrl) begin
                        raw_next = RAW_CTRL;
                    end
                end
                if (first_reg) begin
                    first_next     = 1'b0;
                    start_bad_next = !cls.is_slash;
                end else if (cls.is_slash) begin
                    new_code  = end_code;
                    esc_next  = ESC_NONE;
                    hi_next   = 4'd0;
                    cnt_next  = '0;
                    dots_next = 1'b1;
                end else begin
                    unique case (esc_reg)
                        ESC_HIGH: begin
                            if (cls.hex_ok) begin
                                hi_next  = cls.hex_val;
                                esc_next = ESC_LOW;
                            end else begin
                                new_code = ST_BAD_ESC;
                                esc_next = ESC_NONE;
                            end
                        end
                        ESC_LOW: begin
                            esc_next = ESC_NONE;
                            if (cls.hex_ok) begin
                                take     = 1'b1;
                                dec_byte = {hi_reg, cls.hex_val};
                            end else begin
                                new_code = ST_BAD_ESC;
                            end
                        end
                        default: begin
                            if (cls.is_pct) begin
                                esc_next = ESC_HIGH;
                            end else begin
                                take = 1'b1;
                            end
                        end
                    endcase
                    if (take) begin
                        if (is_unsafe(dec_byte)) begin
                            new_code = ST_UNSAFE;
                        end else if (cnt_reg == CNT_MAX) begin
                            new_code = ST_TOO_LONG;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                            if (dec_byte != CH_DOT) begin
                                dots_next = 1'b0;
                            end
                        end
                    end
                end
            end
        end

        if (accept && cls.is_zero) begin
            seg_next = ST_OK;
        end else if (seg_reg == ST_OK) begin
            seg_next = new_code;
        end else begin
            seg_next = seg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg     <= 1'b1;
            start_bad_reg <= 1'b0;
            raw_reg       <= RAW_NONE;
            seg_reg       <= ST_OK;
            esc_reg       <= ESC_NONE;
            hi_reg        <= 4'd0;
            cnt_reg       <= '0;
            dots_reg      <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            first_reg     <= first_next;
            start_bad_reg <= start_bad_next;
            raw_reg       <= raw_next;
            seg_reg       <= seg_next;
            esc_reg       <= esc_next;
            hi_reg        <= hi_next;
            cnt_reg       <= cnt_next;
            dots_reg      <= dots_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
    end

    `UPTC_ASSERT_NEXT(a_term_gives_beat, accept && cls.is_zero, m_valid_reg && first_reg)
    `UPTC_ASSERT_NEXT(a_empty_path, accept && cls.is_zero && first_reg, m_status_reg == ST_EMPTY)
    `UPTC_ASSERT_NEXT(a_no_spurious_beat, accept && !cls.is_zero && !(m_valid_reg && !m_ready), !m_valid_reg)
    `UPTC_ASSERT_SAME(a_clean_first, first_reg, esc_reg == ESC_NONE && cnt_reg == '0 && seg_reg == ST_OK)

endmodule

[test/url_path_traversal_checker_unit_tb.sv]
// ---------------------------------------------------------------------------
// testbench: url_path_traversal_checker_unit
// Streams resource paths byte by byte into the checker. The monitor keeps a
// cycle-free model of the path scan that produces the status each
// terminating byte should yield. It compares every m_status beat with the
// oldest pending status. Paths are a short hand-written set, then random
// well-formed and broken paths.
// Both sides insert random idle cycles, except for one stretch with none.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import uptc_pkg::*;

    localparam int          IDLE_PCT    = 27;
    localparam logic [7:0]  PATH_END    = 8'h00;
    localparam int          TOTAL_BYTES = 1200;

    typedef enum logic [1:0] {
        RAW_NONE,
        RAW_BS_COLON,
        RAW_CTRL
    } raw_err_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_HI,
        ESC_LO
    } esc_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_path_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [3:0] m_status;

    logic [7:0] path_q[$];
    status_t    status_q[$];
    int         mismatches = 0;
    int         cycle_no   = 0;
    logic       calm;

    // path scan state
    logic             at_start;
    logic             lead_bad;
    raw_err_t         raw_flag;
    status_t          seg_flag;
    esc_t             esc_state;
    logic [3:0]       esc_hi;
    logic [CNT_W-1:0] seg_len;
    logic             only_dots;

    url_path_traversal_checker_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_path_byte (s_path_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    assign calm = (cycle_no >= 400) && (cycle_no < 1000);

    // ---- path scan model ----

    function automatic logic hex_value(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'h0;
        if (c >= "0" && c <= "9") begin
            nib = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            nib = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            nib = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void flag_seg(input status_t code);
        if (seg_flag == ST_OK) begin
            seg_flag = code;
        end
    endfunction

    function automatic void clear_seg();
        esc_state = ESC_NONE;
        esc_hi    = 4'h0;
        seg_len   = '0;
        only_dots = 1'b1;
    endfunction

    function automatic void path_reset();
        at_start = 1'b1;
        lead_bad = 1'b0;
        raw_flag = RAW_NONE;
        seg_flag = ST_OK;
        clear_seg();
    endfunction

    function automatic void push_decoded(input logic [7:0] c);
        if (c == CH_SLASH || c == CH_BSLASH || c == CH_COLON || c == 8'h00) begin
            flag_seg(ST_UNSAFE);
        end else if (seg_len == CNT_MAX) begin
            flag_seg(ST_TOO_LONG);
        end else begin
            seg_len = seg_len + 1'b1;
            if (c != CH_DOT) begin
                only_dots = 1'b0;
            end
        end
    endfunction

    function automatic void close_seg();
        if (esc_state != ESC_NONE) begin
            flag_seg(ST_BAD_ESC);
        end
        if (seg_flag == ST_OK && only_dots && seg_len != '0 && seg_len <= CNT_TWO) begin
            flag_seg(ST_DOT);
        end
        clear_seg();
    endfunction

    function automatic void scan_path_byte(input logic [7:0] c);
        logic [3:0] nib;
        logic       ok;
        status_t    st;
        if (c == PATH_END) begin
            if (at_start) begin
                st = ST_EMPTY;
            end else begin
                close_seg();
                if (lead_bad) begin
                    st = ST_NO_SLASH;
                end else if (raw_flag == RAW_BS_COLON) begin
                    st = ST_BS_COLON;
                end else if (raw_flag == RAW_CTRL) begin
                    st = ST_CTRL;
                end else begin
                    st = seg_flag;
                end
            end
            status_q.push_back(st);
            path_reset();
        end else begin
            if (raw_flag == RAW_NONE) begin
                if (c == CH_BSLASH || c == CH_COLON) begin
                    raw_flag = RAW_BS_COLON;
                end else if (c < CH_SPACE || c == CH_DEL) begin
                    raw_flag = RAW_CTRL;
                end
            end
            if (at_start) begin
                at_start = 1'b0;
                lead_bad = (c != CH_SLASH);
            end else if (c == CH_SLASH) begin
                close_seg();
            end else begin
                case (esc_state)
                    ESC_HI: begin
                        ok = hex_value(c, nib);
                        if (ok) begin
                            esc_hi    = nib;
                            esc_state = ESC_LO;
                        end else begin
                            flag_seg(ST_BAD_ESC);
                            esc_state = ESC_NONE;
                        end
                    end
                    ESC_LO: begin
                        esc_state = ESC_NONE;
                        ok = hex_value(c, nib);
                        if (ok) begin
                            push_decoded({esc_hi, nib});
                        end else begin
                            flag_seg(ST_BAD_ESC);
                        end
                    end
                    default: begin
                        if (c == CH_PCT) begin
                            esc_state = ESC_HI;
                        end else begin
                            push_decoded(c);
                        end
                    end
                endcase
            end
        end
    endfunction

    // ---- stimulus helpers ----

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'("0" + n);
        end
        if ($urandom_range(1) != 0) begin
            return 8'("A" + n - 4'd10);
        end
        return 8'("a" + n - 4'd10);
    endfunction

    function automatic void push_escape(input logic [7:0] v);
        path_q.push_back(CH_PCT);
        path_q.push_back(hex_char(v[7:4]));
        path_q.push_back(hex_char(v[3:0]));
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(8'h21, 8'hff));
        end while (c == CH_SLASH || c == CH_PCT || c == CH_BSLASH || c == CH_COLON ||
                   c == CH_DEL);
        return c;
    endfunction

    function automatic void add_text_path(input string s);
        for (int i = 0; i < s.len(); i++) begin
            path_q.push_back(s[i]);
        end
        path_q.push_back(PATH_END);
    endfunction

    // ---- driver ----

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (path_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid     <= 1'b1;
                s_path_byte <= path_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---- monitor ----

    always @(posedge aclk) begin
        status_t want;
        if (!aresetn) begin
            path_reset();
        end else begin
            if (s_valid && s_ready) begin
                scan_path_byte(s_path_byte);
            end
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    $error("m_status: no beat expected, got %0d", m_status);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    if (m_status !== want) begin
                        $error("m_status: expected %0d, got %0d", want, m_status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ---- stimulus and end of run ----

    initial begin
        int         nseg;
        int         kind;
        logic [7:0] v;

        add_text_path("");
        add_text_path("/");
        add_text_path("abc");
        add_text_path("x\\");
        add_text_path("/a\\b");
        add_text_path("/a:b");
        add_text_path("/a%4");
        add_text_path("/a%zz/b");
        add_text_path("/%%41");
        add_text_path("/%4g");
        add_text_path("/a%2f");
        add_text_path("/%5C/%3a");
        add_text_path("/%00");
        add_text_path("/.");
        add_text_path("/x/../y");
        add_text_path("/%2e%2E");
        add_text_path("/.../a%41%ff/");
        add_text_path("/%zz\\");
        add_text_path("/a/.%2/..");
        // raw control bytes, both ends of the range and DEL
        path_q.push_back(CH_SLASH);
        path_q.push_back(8'h01);
        path_q.push_back(PATH_END);
        path_q.push_back(CH_SLASH);
        path_q.push_back(8'h1f);
        path_q.push_back(PATH_END);
        path_q.push_back(CH_SLASH);
        path_q.push_back(CH_DEL);
        path_q.push_back(8'hff);
        path_q.push_back(PATH_END);

        while (path_q.size() < TOTAL_BYTES) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(0, 8)) path_q.push_back(8'($urandom_range(1, 255)));
            end else begin
                if ($urandom_range(19) != 0) begin
                    path_q.push_back(CH_SLASH);
                end else begin
                    path_q.push_back(plain_char());
                end
                nseg = $urandom_range(0, 4);
                for (int i = 0; i < nseg; i++) begin
                    if (i != 0) begin
                        path_q.push_back(CH_SLASH);
                    end
                    kind = $urandom_range(9);
                    case (kind)
                        0: begin
                            repeat ($urandom_range(1, 3)) begin
                                if ($urandom_range(1) != 0) begin
                                    path_q.push_back(CH_DOT);
                                end else begin
                                    push_escape(CH_DOT);
                                end
                            end
                        end
                        1: begin
                            repeat ($urandom_range(1, 4)) push_escape(8'($urandom_range(255)));
                        end
                        2: begin
                            path_q.push_back(CH_PCT);
                            repeat ($urandom_range(0, 2)) begin
                                v = 8'($urandom_range(1, 255));
                                path_q.push_back(v == CH_SLASH ? CH_PCT : v);
                            end
                        end
                        3: begin
                            path_q.push_back(8'($urandom_range(1, 255)));
                        end
                        default: begin
                            repeat ($urandom_range(1, 8)) begin
                                if ($urandom_range(3) == 0) begin
                                    push_escape(plain_char());
                                end else begin
                                    path_q.push_back(plain_char());
                                end
                            end
                        end
                    endcase
                end
                if ($urandom_range(7) == 0) begin
                    path_q.push_back(CH_SLASH);
                end
            end
            path_q.push_back(PATH_END);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (path_q.size() != 0 || s_valid || status_q.size() != 0);
        repeat (10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("PASS url_path_traversal_checker_unit");
        end else begin
            $display("FAIL url_path_traversal_checker_unit");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL url_path_traversal_checker_unit");
        $finish;
    end

endmodule
